>>> hdl/fss_pkg.sv
// fourier series synthesis: shared constants, cordic angle table, types
// no dependencies
`timescale 1ns / 1ps

package fss_pkg;

  localparam int MaxTermsDefault = 64;
  localparam int CordicSteps     = 16;
  localparam int CordicAngW      = 32;
  localparam int SumW            = 40;
  localparam logic signed [17:0] CordicX0 = 18'sd19898;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  // rotation step angles, fraction of a turn scaled by 2^32
  function automatic logic signed [CordicAngW-1:0] turn_atan(input logic [3:0] i);
    case (i)
      4'd0:  turn_atan = 32'sh20000000;
      4'd1:  turn_atan = 32'sh12E4051E;
      4'd2:  turn_atan = 32'sh09FB385B;
      4'd3:  turn_atan = 32'sh051111D4;
      4'd4:  turn_atan = 32'sh028B0D43;
      4'd5:  turn_atan = 32'sh0145D7E1;
      4'd6:  turn_atan = 32'sh00A2F61E;
      4'd7:  turn_atan = 32'sh00517C55;
      4'd8:  turn_atan = 32'sh0028BE53;
      4'd9:  turn_atan = 32'sh00145F2F;
      4'd10: turn_atan = 32'sh000A2F98;
      4'd11: turn_atan = 32'sh000517CC;
      4'd12: turn_atan = 32'sh00028BE6;
      4'd13: turn_atan = 32'sh000145F3;
      4'd14: turn_atan = 32'sh0000A2FA;
      default: turn_atan = 32'sh0000517D;
    endcase
  endfunction

  // one word travelling down the cordic chain
  typedef struct packed {
    logic                          vld;
    logic                          last;
    logic [1:0]                    quad;
    logic signed [17:0]            x;
    logic signed [17:0]            y;
    logic signed [CordicAngW-1:0]  z;
    logic signed [15:0]            cr;
    logic signed [15:0]            ci;
  } cord_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    if (v > 19'sd32767) sat16 = 16'sh7FFF;
    else if (v < -19'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction

endpackage

>>> hdl/fourier_series_synthesis.sv
// top level: term table, phase multiply, chain of cordic cells, complex mac
// depends on fss_pkg, fss_ram, fss_cell
`timescale 1ns / 1ps
//
// channel  dir  fields (low bit first)
// s_axis   in   tdata: term_index[5:0] frequency[37:6] coef_real[53:38]
//                      coef_imag[69:54] sample_time[101:70]; tuser: op
// m_axis   out  tdata: sum_real[39:0] sum_imag[79:40]
// apb      in   reg 0 at 0x0: num_terms
//
// a load word is written into the table when it is accepted; an evaluate word over n
// effective terms runs as one table read per cycle, which feeds the
// phase multiplier and a 16-cell cordic chain, then the chain drains into the mac.
// reset clears control and sets num_terms to 1; the table is not cleared.
// a result waits in the output register; a new word is taken once it is free.

module fourier_series_synthesis
  import fss_pkg::*;
#(
  parameter int MaxTerms = MaxTermsDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // term_index, frequency, coef_real, coef_imag, sample_time
  input  logic         s_axis_tuser,   // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [79:0]  m_axis_tdata,   // sum_real, sum_imag
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int CW = AW + 1;

  logic [5:0]  in_idx;
  logic [31:0] in_freq, in_time;
  logic [15:0] in_cr, in_ci;
  logic [AW-1:0] waddr;
  assign in_idx  = s_axis_tdata[5:0];
  assign in_freq = s_axis_tdata[37:6];
  assign in_cr   = s_axis_tdata[53:38];
  assign in_ci   = s_axis_tdata[69:54];
  assign in_time = s_axis_tdata[101:70];
  assign waddr   = AW'(in_idx);

  // configuration register
  logic [6:0] num_terms;
  assign pready = 1'b1;
  assign prdata = {25'd0, num_terms};
  always_ff @(posedge clk) begin
    if (rst) num_terms <= 7'd1;
    else if (psel && penable && pwrite && paddr == 2'd0) num_terms <= pwdata[6:0];
  end

  // effective term count
  logic [CW-1:0] n_eff;
  always_comb begin
    if (num_terms == 7'd0) n_eff = CW'(1);
    else if (32'(num_terms) > MaxTerms) n_eff = CW'(MaxTerms);
    else n_eff = CW'(num_terms);
  end

  // sequencer
  logic          busy, issuing, out_vld;
  logic [CW-1:0] rd_cnt, n_run;
  logic [31:0]   t_run;
  logic          accept, load_ok;
  assign s_axis_tready = !busy && !out_vld;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign load_ok = accept && s_axis_tuser == OP_LOAD && 32'(in_idx) < MaxTerms;

  logic [AW-1:0] raddr;
  assign raddr = rd_cnt[AW-1:0];

  logic [31:0] f_rd;
  logic [15:0] cr_rd, ci_rd;
  fss_ram #(.Width(32), .Depth(MaxTerms)) u_freq (
    .clk, .we(load_ok), .waddr, .wdata(in_freq),
    .raddr, .rdata(f_rd));
  fss_ram #(.Width(16), .Depth(MaxTerms)) u_cr (
    .clk, .we(load_ok), .waddr, .wdata(in_cr),
    .raddr, .rdata(cr_rd));
  fss_ram #(.Width(16), .Depth(MaxTerms)) u_ci (
    .clk, .we(load_ok), .waddr, .wdata(in_ci),
    .raddr, .rdata(ci_rd));

  logic rd_vld, rd_last;
  logic last_done;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; issuing <= 1'b0; rd_vld <= 1'b0; rd_cnt <= '0;
    end else begin
      rd_vld <= issuing;
      if (accept && s_axis_tuser == OP_EVAL) begin
        busy <= 1'b1; issuing <= 1'b1; rd_cnt <= '0; n_run <= n_eff; t_run <= in_time;
      end else if (issuing) begin
        rd_cnt <= rd_cnt + CW'(1);
        if (rd_cnt + CW'(1) == n_run) issuing <= 1'b0;
      end
      if (last_done) busy <= 1'b0;
    end
    rd_last <= issuing && (rd_cnt + CW'(1) == n_run);
  end

  // phase multiply, low 32 bits
  logic        ph_vld, ph_last;
  logic [31:0] phase;
  logic [15:0] ph_cr, ph_ci;
  always_ff @(posedge clk) begin
    if (rst) ph_vld <= 1'b0;
    else ph_vld <= rd_vld;
    ph_last <= rd_last;
    phase   <= f_rd * t_run;
    ph_cr   <= cr_rd;
    ph_ci   <= ci_rd;
  end

  // chain head: quadrant and residual angle
  logic [31:0] shifted;
  cord_t chain [CordicSteps+1];
  assign shifted = phase + 32'h20000000;
  assign chain[0].vld  = ph_vld;
  assign chain[0].last = ph_last;
  assign chain[0].quad = shifted[31:30];
  assign chain[0].x    = CordicX0;
  assign chain[0].y    = '0;
  assign chain[0].z    = $signed({2'b00, shifted[29:0]}) - 32'sh20000000;
  assign chain[0].cr   = ph_cr;
  assign chain[0].ci   = ph_ci;

  for (genvar g = 0; g < CordicSteps; g++) begin : g_cell
    fss_cell #(.Step(g)) u_cell (.clk, .rst, .din(chain[g]), .dout(chain[g+1]));
  end

  // quadrant fold and saturation
  cord_t ce;
  assign ce = chain[CordicSteps];
  logic signed [18:0] cv, sv;
  always_comb begin
    case (ce.quad)
      2'd0: begin cv = 19'(ce.x);  sv = 19'(ce.y);  end
      2'd1: begin cv = -19'(ce.y); sv = 19'(ce.x);  end
      2'd2: begin cv = -19'(ce.x); sv = -19'(ce.y); end
      default: begin cv = 19'(ce.y); sv = -19'(ce.x); end
    endcase
  end

  logic               q_vld, q_last;
  logic signed [15:0] c_q, s_q, cr_q, ci_q;
  always_ff @(posedge clk) begin
    if (rst) q_vld <= 1'b0;
    else q_vld <= ce.vld;
    q_last <= ce.last;
    c_q <= sat16(cv); s_q <= sat16(sv); cr_q <= ce.cr; ci_q <= ce.ci;
  end

  // four products, registered
  logic               p_vld, p_last;
  logic signed [31:0] p_rc, p_is, p_rs, p_ic;
  always_ff @(posedge clk) begin
    if (rst) p_vld <= 1'b0;
    else p_vld <= q_vld;
    p_last <= q_last;
    p_rc <= cr_q * c_q; p_is <= ci_q * s_q;
    p_rs <= cr_q * s_q; p_ic <= ci_q * c_q;
  end

  // accumulate; clears after the last term
  logic signed [SumW-1:0] acc_re, acc_im, nre, nim;
  assign nre = acc_re + SumW'(p_rc) - SumW'(p_is);
  assign nim = acc_im + SumW'(p_rs) + SumW'(p_ic);
  assign last_done = p_vld && p_last;
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_re <= '0; acc_im <= '0; out_vld <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) out_vld <= 1'b0;
      if (p_vld) begin
        if (p_last) begin
          acc_re <= '0; acc_im <= '0; out_vld <= 1'b1;
          m_axis_tdata <= {nim, nre};
        end else begin
          acc_re <= nre; acc_im <= nim;
        end
      end
    end
  end
  assign m_axis_tvalid = out_vld;

  // checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready) else $error("word accepted while busy");
  a_issue_in_busy: assert property (@(posedge clk) disable iff (rst)
    issuing |-> busy) else $error("table read outside a run");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_vld && !m_axis_tready |=> out_vld) else $error("result dropped");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    last_done |-> busy && !out_vld) else $error("stray result");

endmodule

>>> hdl/fss_ram.sv
// generic single-port write, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module fss_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/fss_cell.sv
// one cordic rotation cell of the chain, fixed shift set by parameter
// depends on fss_pkg
`timescale 1ns / 1ps

module fss_cell
  import fss_pkg::*;
#(
  parameter int Step = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  cord_t din,
  output cord_t dout
);

  logic signed [17:0] dx, dy;
  logic signed [CordicAngW-1:0] ang;

  assign dx  = din.y >>> Step;
  assign dy  = din.x >>> Step;
  assign ang = turn_atan(4'(Step));

  // rotate toward zero residual and hand the word on
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.last <= din.last;
    dout.quad <= din.quad;
    dout.cr   <= din.cr;
    dout.ci   <= din.ci;
    if (!din.z[CordicAngW-1]) begin
      dout.x <= din.x - dx;
      dout.y <= din.y + dy;
      dout.z <= din.z - ang;
    end else begin
      dout.x <= din.x + dx;
      dout.y <= din.y - dy;
      dout.z <= din.z + ang;
    end
  end

endmodule
